// File: rtl/core/mtbl_pkg.sv
// ---------------------------------------------------------------------------
// mtbl_pkg
// Shared types, codes and helpers of the multi-slot token bucket limiter.
// ---------------------------------------------------------------------------
`default_nettype none

package mtbl_pkg;

    // Table size and token counter width
    localparam int NUM_BUCKETS = 32;
    localparam int TOKEN_BITS  = 16;

    // Fixed port field widths
    localparam int OPCODE_W = 3;
    localparam int ID_W     = 5;
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 2;

    // Derived widths
    localparam int IDX_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CALC_W = (TOKEN_BITS > FIELD_W) ? TOKEN_BITS : FIELD_W;
    localparam int SUM_W  = CALC_W + 1;

    // Largest token count, at sum width
    localparam logic [SUM_W-1:0] TOKEN_MAX_S =
        {{(SUM_W - TOKEN_BITS){1'b0}}, {TOKEN_BITS{1'b1}}};

    // Command opcodes
    localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_FETCH   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_RETURN  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BLOCK = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TICK
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;   // command transfer accepted this cycle
        logic exec;   // single-slot read-modify-write
        logic tick;   // one slot of the refill sweep
    } t_ctl_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic req_tick;   // incoming command is a tick
        logic tick_last;  // sweep is at the last slot
    } t_dp_stat;

    // One slot of the bucket table
    typedef struct packed {
        logic [FIELD_W-1:0]    rate;
        logic [FIELD_W-1:0]    cap;
        logic [TOKEN_BITS-1:0] tokens;
    } t_entry;

    // Add to a token count, saturating at the cap and at the counter range
    function automatic logic [TOKEN_BITS-1:0] clamp_add(
        input logic [TOKEN_BITS-1:0] tokens,
        input logic [FIELD_W-1:0]    add,
        input logic [FIELD_W-1:0]    cap
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(tokens) + SUM_W'(add);
        if (sum > SUM_W'(cap)) begin
            sum = SUM_W'(cap);
        end
        if (sum > TOKEN_MAX_S) begin
            sum = TOKEN_MAX_S;
        end
        return TOKEN_BITS'(sum);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mtbl_ctrl.sv
// ---------------------------------------------------------------------------
// mtbl_ctrl
// Command sequencer: accepts a command, runs the execute state or the
// refill sweep over all slots, then returns to idle.
// ---------------------------------------------------------------------------
`default_nettype none

module mtbl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  mtbl_pkg::t_dp_stat i_stat,
    output mtbl_pkg::t_ctl_cmd o_cmd,
    output logic               busy
);
    import mtbl_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = i_stat.req_tick ? S_TICK : S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            S_TICK: begin
                if (i_stat.tick_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_TICK: begin
                o_cmd.tick = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/mtbl_datapath.sv
// ---------------------------------------------------------------------------
// mtbl_datapath
// Bucket table memory, valid bits, free-slot encoder, token arithmetic
// and the result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module mtbl_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mtbl_pkg::t_ctl_cmd              i_cmd,
    output mtbl_pkg::t_dp_stat              o_stat,
    input  logic [mtbl_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [mtbl_pkg::ID_W-1:0]       i_bucket_id,
    input  logic [mtbl_pkg::FIELD_W-1:0]    i_amount,
    input  logic [mtbl_pkg::FIELD_W-1:0]    i_rate,
    input  logic [mtbl_pkg::FIELD_W-1:0]    i_burst_limit,
    output logic                            o_strobe,
    output logic [mtbl_pkg::STATUS_W-1:0]   o_status,
    output logic [mtbl_pkg::ID_W-1:0]       o_slot,
    output logic [mtbl_pkg::FIELD_W-1:0]    o_granted
);
    import mtbl_pkg::*;

    // Captured command
    logic [OPCODE_W-1:0] r_op;
    logic [ID_W-1:0]     r_id;
    logic [FIELD_W-1:0]  r_amount;
    logic [FIELD_W-1:0]  r_rate;
    logic [FIELD_W-1:0]  r_cap;

    // Table storage
    t_entry                 r_mem [NUM_BUCKETS];
    t_entry                 r_rd_data;
    logic [NUM_BUCKETS-1:0] r_valid;

    // Sweep counter and free-slot encoder
    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_free_idx;
    logic             r_free_any;
    logic [IDX_W-1:0] n_free_idx;
    logic             n_free_any;

    // Result registers
    logic                r_strobe;
    logic [STATUS_W-1:0] r_status;
    logic [ID_W-1:0]     r_slot;
    logic [FIELD_W-1:0]  r_granted;

    // Combinational datapath
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    id_idx;
    logic                id_live;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    t_entry              mem_wdata;
    logic                valid_set;
    logic                valid_clr;
    logic                finish;
    logic [STATUS_W-1:0] res_status;
    logic [ID_W-1:0]     res_slot;
    logic [FIELD_W-1:0]  res_granted;
    logic [CALC_W-1:0]   grant_w;

    assign id_idx  = IDX_W'(r_id);
    assign id_live = (32'(r_id) < NUM_BUCKETS) && r_valid[id_idx];

    assign o_stat.req_tick  = (i_opcode == OP_TICK);
    assign o_stat.tick_last = (r_cnt == IDX_W'(NUM_BUCKETS - 1));

    assign finish = i_cmd.exec || (i_cmd.tick && o_stat.tick_last);

    // Command capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_id     <= i_bucket_id;
            r_amount <= i_amount;
            r_rate   <= i_rate;
            r_cap    <= i_burst_limit;
        end
    end

    // Read address: addressed slot on transfer, sweep slot after that
    always_comb begin
        if (i_cmd.load) begin
            rd_addr = o_stat.req_tick ? '0 : IDX_W'(i_bucket_id);
        end else begin
            rd_addr = r_cnt + IDX_W'(1);
        end
    end

    // Sweep counter: slot whose data sits in the read register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.tick) begin
            r_cnt <= r_cnt + IDX_W'(1);
        end
    end

    // Lowest free slot, registered every cycle
    always_comb begin
        n_free_idx = '0;
        n_free_any = 1'b0;
        for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                n_free_idx = IDX_W'(i);
                n_free_any = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_free_idx <= n_free_idx;
        r_free_any <= n_free_any;
    end

    // Read-modify-write of one slot
    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = id_idx;
        mem_wdata   = r_rd_data;
        valid_set   = 1'b0;
        valid_clr   = 1'b0;
        res_status  = STAT_OK;
        res_slot    = r_id;
        res_granted = '0;
        grant_w     = '0;

        // refill sweep step
        if (i_cmd.tick) begin
            mem_waddr        = r_cnt;
            mem_we           = r_valid[r_cnt];
            mem_wdata.tokens = clamp_add(r_rd_data.tokens, r_rd_data.rate, r_rd_data.cap);
        end

        if (i_cmd.exec) begin
            case (r_op)
                OP_ALLOC: begin
                    if (r_free_any) begin
                        mem_we           = 1'b1;
                        mem_waddr        = r_free_idx;
                        mem_wdata.rate   = r_rate;
                        mem_wdata.cap    = r_cap;
                        mem_wdata.tokens = '0;
                        valid_set        = 1'b1;
                        res_slot         = ID_W'(r_free_idx);
                    end else begin
                        res_status = STAT_FULL;
                        res_slot   = '0;
                    end
                end
                OP_FETCH: begin
                    if (!id_live || (r_rd_data.tokens == '0)) begin
                        res_status = STAT_BLOCK;
                    end else begin
                        if (CALC_W'(r_rd_data.tokens) < CALC_W'(r_amount)) begin
                            grant_w = CALC_W'(r_rd_data.tokens);
                        end else begin
                            grant_w = CALC_W'(r_amount);
                        end
                        mem_we           = 1'b1;
                        mem_wdata.tokens =
                            TOKEN_BITS'(CALC_W'(r_rd_data.tokens) - grant_w);
                        res_granted      = FIELD_W'(grant_w);
                    end
                end
                OP_RETURN: begin
                    if (id_live) begin
                        mem_we           = 1'b1;
                        mem_wdata.tokens =
                            clamp_add(r_rd_data.tokens, r_amount, r_rd_data.cap);
                    end
                end
                OP_RELEASE: begin
                    valid_clr = id_live;
                end
                default: begin
                    res_status = STAT_OK;
                end
            endcase
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (valid_set) begin
                r_valid[mem_waddr] <= 1'b1;
            end
            if (valid_clr) begin
                r_valid[id_idx] <= 1'b0;
            end
        end
    end

    // Result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_status  <= res_status;
            r_slot    <= res_slot;
            r_granted <= res_granted;
        end
    end

    assign o_strobe  = r_strobe;
    assign o_status  = r_status;
    assign o_slot    = r_slot;
    assign o_granted = r_granted;

    // Checks
    a_alloc_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == OP_ALLOC) && r_free_any) |=> r_valid[$past(r_free_idx)])
        else $error("allocate did not mark its slot valid");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == OP_RELEASE) && id_live) |=> !r_valid[$past(id_idx)])
        else $error("release left its slot valid");

    a_grant_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == OP_FETCH)) |=> (r_granted <= $past(r_amount)))
        else $error("grant exceeds request");

    a_block_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_status == STAT_BLOCK)) |-> (r_granted == '0))
        else $error("would-block result carries a grant");

    a_tick_no_valid_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick |=> $stable(r_valid))
        else $error("refill sweep changed slot ownership");

endmodule

`default_nettype wire

// File: rtl/core/multi_token_bucket_limiter.sv
// ---------------------------------------------------------------------------
// multi_token_bucket_limiter
// Table of token buckets with allocate, tick refill, fetch, return and
// release commands; one result per command.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Allocate, fetch,
// return, release and unknown opcodes pass through the transfer cycle,
// which reads the addressed slot from the table memory, and the execute
// cycle, which updates the table as the opcode needs. A tick sweeps the
// table one slot per cycle, after the transfer cycle, through the memory's
// single write port. The result appears on o_status, o_slot and o_granted
// for exactly one cycle, marked by o_strobe, in the cycle busy drops again;
// the receiver cannot hold it off, so it must capture every strobe.
`default_nettype none

module multi_token_bucket_limiter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [mtbl_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [mtbl_pkg::ID_W-1:0]       i_bucket_id,
    input  logic [mtbl_pkg::FIELD_W-1:0]    i_amount,
    input  logic [mtbl_pkg::FIELD_W-1:0]    i_rate,
    input  logic [mtbl_pkg::FIELD_W-1:0]    i_burst_limit,
    output logic                            o_strobe,
    output logic [mtbl_pkg::STATUS_W-1:0]   o_status,
    output logic [mtbl_pkg::ID_W-1:0]       o_slot,
    output logic [mtbl_pkg::FIELD_W-1:0]    o_granted
);
    import mtbl_pkg::*;

    t_ctl_cmd cmd;
    t_dp_stat stat;

    // Sequencer
    mtbl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Table and arithmetic
    mtbl_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_opcode      (i_opcode),
        .i_bucket_id   (i_bucket_id),
        .i_amount      (i_amount),
        .i_rate        (i_rate),
        .i_burst_limit (i_burst_limit),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_granted     (o_granted)
    );

endmodule

`default_nettype wire
